@@ design/soct_pkg.sv @@
// Shared types, widths and codes for the segment/obstacle collision test.
// No dependencies; every other source file but soct_rsp_if imports this package.
`default_nettype none
package soct_pkg;

	// Coordinate width of all positions in millimetres.
	localparam int CW = 13;
	// Width of doubled rectangle coordinates, grown edges included.
	localparam int DW = ((CW + 1 > 13) ? CW + 1 : 13) + 1;
	// Width of one circle product of two coordinate differences.
	localparam int PW = 2 * CW + 2;

	localparam int ADDR_W = 3;
	localparam logic REG_VEHICLE_WIDTH = 1'b0;
	localparam logic [9:0] VEHICLE_WIDTH_RESET = 10'd300;

	localparam logic [1:0] KIND_CIRCLE = 2'd0;
	localparam logic [1:0] KIND_RECT = 2'd1;
	localparam logic [1:0] KIND_SQUARE = 2'd2;

	typedef enum logic [1:0] {ORI_COLL, ORI_POS, ORI_NEG} orient_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_en_t;

	// Orientation from a sign decision: zero when the edge is degenerate or the
	// point sits on the edge line.
	function automatic orient_t ori_cmp(input logic nz, input logic pos, input logic neg);
		orient_t o;
		o = ORI_COLL;
		if (nz && pos)
			o = ORI_POS;
		else if (nz && neg)
			o = ORI_NEG;
		return o;
	endfunction

endpackage
`default_nettype wire

@@ design/soct_req_if.sv @@
// Request channel: one segment and one obstacle per request.
// Depends on soct_pkg for the coordinate width.
`default_nettype none
interface soct_req_if import soct_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [CW-1:0] start_x;
	logic signed [CW-1:0] start_y;
	logic signed [CW-1:0] end_x;
	logic signed [CW-1:0] end_y;
	logic obstacle_present;
	logic [1:0] obstacle_kind;
	logic signed [CW-1:0] centre_x;
	logic signed [CW-1:0] centre_y;
	logic [9:0] size_a;
	logic [9:0] size_b;

	modport source (output valid, start_x, start_y, end_x, end_y, obstacle_present,
		obstacle_kind, centre_x, centre_y, size_a, size_b, input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, obstacle_present,
		obstacle_kind, centre_x, centre_y, size_a, size_b, output ready);
endinterface
`default_nettype wire

@@ design/soct_rsp_if.sv @@
// Response channel: the blocked flag for one request.
// No dependencies.
`default_nettype none
interface soct_rsp_if ();
	logic valid;
	logic ready;
	logic blocked;

	modport source (output valid, blocked, input ready);
	modport sink (input valid, blocked, output ready);
endinterface
`default_nettype wire

@@ design/soct_circle.sv @@
// Circle test: squared distance from the centre to the clamped segment.
// Pipeline stages s2 to s6; depends on soct_pkg.
`default_nettype none
module soct_circle import soct_pkg::*; (
	input  wire logic clk,
	input  wire stage_en_t en,
	input  wire logic signed [CW-1:0] sx,
	input  wire logic signed [CW-1:0] sy,
	input  wire logic signed [CW-1:0] ex,
	input  wire logic signed [CW-1:0] ey,
	input  wire logic signed [CW-1:0] cx,
	input  wire logic signed [CW-1:0] cy,
	input  wire logic [9:0] a,
	input  wire logic [9:0] rw,
	output logic blk
);
	logic signed [CW:0] dx_s2, dy_s2, fx_s2, fy_s2, gx_s2, gy_s2;
	logic [10:0] r_s2;
	logic signed [PW-1:0] pdx_s3, pdy_s3, pfx_s3, pfy_s3, pc1_s3, pc2_s3;
	logic signed [PW-1:0] pff1_s3, pff2_s3, pgg1_s3, pgg2_s3;
	logic [21:0] r2_s3, r2_s4;
	logic signed [PW:0] l2_s4, dot_s4, cr_s4, df_s4, dg_s4;
	logic signed [2*PW+1:0] cc_s5;
	logic [PW+21:0] rl_s5;
	logic near_s5, far_s5, dfle_s5, dgle_s5;
	logic blk_s6;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			dx_s2 <= $signed({ex[CW-1], ex}) - $signed({sx[CW-1], sx});
			dy_s2 <= $signed({ey[CW-1], ey}) - $signed({sy[CW-1], sy});
			fx_s2 <= $signed({cx[CW-1], cx}) - $signed({sx[CW-1], sx});
			fy_s2 <= $signed({cy[CW-1], cy}) - $signed({sy[CW-1], sy});
			gx_s2 <= $signed({cx[CW-1], cx}) - $signed({ex[CW-1], ex});
			gy_s2 <= $signed({cy[CW-1], cy}) - $signed({ey[CW-1], ey});
			r_s2 <= {1'b0, a} + {2'b00, rw[9:1]};
		end
		if (en.s3) begin
			pdx_s3 <= dx_s2 * dx_s2;
			pdy_s3 <= dy_s2 * dy_s2;
			pfx_s3 <= fx_s2 * dx_s2;
			pfy_s3 <= fy_s2 * dy_s2;
			pc1_s3 <= dx_s2 * fy_s2;
			pc2_s3 <= dy_s2 * fx_s2;
			pff1_s3 <= fx_s2 * fx_s2;
			pff2_s3 <= fy_s2 * fy_s2;
			pgg1_s3 <= gx_s2 * gx_s2;
			pgg2_s3 <= gy_s2 * gy_s2;
			r2_s3 <= r_s2 * r_s2;
		end
		if (en.s4) begin
			l2_s4 <= $signed({pdx_s3[PW-1], pdx_s3}) + $signed({pdy_s3[PW-1], pdy_s3});
			dot_s4 <= $signed({pfx_s3[PW-1], pfx_s3}) + $signed({pfy_s3[PW-1], pfy_s3});
			cr_s4 <= $signed({pc1_s3[PW-1], pc1_s3}) - $signed({pc2_s3[PW-1], pc2_s3});
			df_s4 <= $signed({pff1_s3[PW-1], pff1_s3}) + $signed({pff2_s3[PW-1], pff2_s3});
			dg_s4 <= $signed({pgg1_s3[PW-1], pgg1_s3}) + $signed({pgg2_s3[PW-1], pgg2_s3});
			r2_s4 <= r2_s3;
		end
		if (en.s5) begin
			// The square of the cross product is the same whatever its sign.
			cc_s5 <= cr_s4 * cr_s4;
			rl_s5 <= r2_s4 * l2_s4[PW-1:0];
			near_s5 <= (l2_s4 == 0) || (dot_s4 <= 0);
			far_s5 <= dot_s4 >= l2_s4;
			dfle_s5 <= $unsigned(df_s4) <= r2_s4;
			dgle_s5 <= $unsigned(dg_s4) <= r2_s4;
		end
		if (en.s6) begin
			if (near_s5)
				blk_s6 <= dfle_s5;
			else if (far_s5)
				blk_s6 <= dgle_s5;
			else
				blk_s6 <= $unsigned(cc_s5) <= rl_s5;
		end
	end

	assign blk = blk_s6;
endmodule
`default_nettype wire

@@ design/soct_rect.sv @@
// Rectangle and square test on doubled coordinates: endpoint inside, or an
// edge crossed by the orientation test. Pipeline stages s2 to s6; uses soct_pkg.
`default_nettype none
module soct_rect import soct_pkg::*; (
	input  wire logic clk,
	input  wire stage_en_t en,
	input  wire logic signed [CW-1:0] sx,
	input  wire logic signed [CW-1:0] sy,
	input  wire logic signed [CW-1:0] ex,
	input  wire logic signed [CW-1:0] ey,
	input  wire logic signed [CW-1:0] cx,
	input  wire logic signed [CW-1:0] cy,
	input  wire logic [9:0] a,
	input  wire logic [9:0] b,
	input  wire logic square,
	input  wire logic [9:0] rw,
	output logic blk
);
	localparam int XW = DW - CW - 1;
	localparam int QW = 2 * DW + 2;

	logic [11:0] hw2, hh2;
	logic [9:0] hb;
	logic signed [DW-1:0] ax_s2, ay_s2, bx_s2, by_s2, lf_s2, rt_s2, bt_s2, tp_s2;
	logic hwnz_s2, hhnz_s2;

	logic signed [DW-1:0] kx [4];
	logic signed [DW-1:0] ky [4];
	orient_t oa [4];
	orient_t ob [4];
	logic signed [DW:0] ux_s3, uy_s3;
	logic signed [DW:0] kxd_s3 [4];
	logic signed [DW:0] kyd_s3 [4];
	logic inside_s3, inside_s4, inside_s5, inside_s6;
	logic [3:0] cdne_s3, cdne_s4, cdne_s5;

	logic signed [QW-1:0] p1_s4 [4];
	logic signed [QW-1:0] p2_s4 [4];
	logic signed [QW:0] val [4];
	orient_t oc_s5 [4];
	logic [3:0] hit;

	assign hb = square ? a : b;
	assign hw2 = {1'b0, a, 1'b0} + {2'b00, rw};
	assign hh2 = {1'b0, hb, 1'b0} + {2'b00, rw};

	always_ff @(posedge clk) begin
		if (en.s2) begin
			ax_s2 <= $signed({{XW{sx[CW-1]}}, sx, 1'b0});
			ay_s2 <= $signed({{XW{sy[CW-1]}}, sy, 1'b0});
			bx_s2 <= $signed({{XW{ex[CW-1]}}, ex, 1'b0});
			by_s2 <= $signed({{XW{ey[CW-1]}}, ey, 1'b0});
			lf_s2 <= $signed({{XW{cx[CW-1]}}, cx, 1'b0}) - $signed({{(DW-12){1'b0}}, hw2});
			rt_s2 <= $signed({{XW{cx[CW-1]}}, cx, 1'b0}) + $signed({{(DW-12){1'b0}}, hw2});
			bt_s2 <= $signed({{XW{cy[CW-1]}}, cy, 1'b0}) - $signed({{(DW-12){1'b0}}, hh2});
			tp_s2 <= $signed({{XW{cy[CW-1]}}, cy, 1'b0}) + $signed({{(DW-12){1'b0}}, hh2});
			hwnz_s2 <= hw2 != 12'd0;
			hhnz_s2 <= hh2 != 12'd0;
		end
	end

	// Corners in order: left bottom, right bottom, right top, left top. Edge e
	// runs from corner e to corner e+1, so the outline goes counterclockwise.
	always_comb begin
		kx[0] = lf_s2;
		ky[0] = bt_s2;
		kx[1] = rt_s2;
		ky[1] = bt_s2;
		kx[2] = rt_s2;
		ky[2] = tp_s2;
		kx[3] = lf_s2;
		ky[3] = tp_s2;
		// Edges are axis aligned, so the orientation of an endpoint against an
		// edge reduces to which side of the edge line it lies on.
		oa[0] = ori_cmp(hwnz_s2, ay_s2 < bt_s2, ay_s2 > bt_s2);
		ob[0] = ori_cmp(hwnz_s2, by_s2 < bt_s2, by_s2 > bt_s2);
		oa[1] = ori_cmp(hhnz_s2, ax_s2 > rt_s2, ax_s2 < rt_s2);
		ob[1] = ori_cmp(hhnz_s2, bx_s2 > rt_s2, bx_s2 < rt_s2);
		oa[2] = ori_cmp(hwnz_s2, ay_s2 > tp_s2, ay_s2 < tp_s2);
		ob[2] = ori_cmp(hwnz_s2, by_s2 > tp_s2, by_s2 < tp_s2);
		oa[3] = ori_cmp(hhnz_s2, ax_s2 < lf_s2, ax_s2 > lf_s2);
		ob[3] = ori_cmp(hhnz_s2, bx_s2 < lf_s2, bx_s2 > lf_s2);
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			ux_s3 <= $signed({bx_s2[DW-1], bx_s2}) - $signed({ax_s2[DW-1], ax_s2});
			uy_s3 <= $signed({by_s2[DW-1], by_s2}) - $signed({ay_s2[DW-1], ay_s2});
			for (int k = 0; k < 4; k++) begin
				kxd_s3[k] <= $signed({kx[k][DW-1], kx[k]}) - $signed({bx_s2[DW-1], bx_s2});
				kyd_s3[k] <= $signed({ky[k][DW-1], ky[k]}) - $signed({by_s2[DW-1], by_s2});
				cdne_s3[k] <= oa[k] != ob[k];
			end
			inside_s3 <= (ax_s2 >= lf_s2 && ax_s2 <= rt_s2 && ay_s2 >= bt_s2 && ay_s2 <= tp_s2)
				|| (bx_s2 >= lf_s2 && bx_s2 <= rt_s2 && by_s2 >= bt_s2 && by_s2 <= tp_s2);
		end
		if (en.s4) begin
			for (int k = 0; k < 4; k++) begin
				p1_s4[k] <= uy_s3 * kxd_s3[k];
				p2_s4[k] <= ux_s3 * kyd_s3[k];
			end
			inside_s4 <= inside_s3;
			cdne_s4 <= cdne_s3;
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++)
			val[k] = $signed({p1_s4[k][QW-1], p1_s4[k]}) - $signed({p2_s4[k][QW-1], p2_s4[k]});
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			for (int k = 0; k < 4; k++) begin
				if (val[k] == 0)
					oc_s5[k] <= ORI_COLL;
				else if (val[k][QW])
					oc_s5[k] <= ORI_NEG;
				else
					oc_s5[k] <= ORI_POS;
			end
			inside_s5 <= inside_s4;
			cdne_s5 <= cdne_s4;
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++)
			hit[k] = (oc_s5[k] != oc_s5[(k + 1) % 4]) && cdne_s5[k];
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			inside_s6 <= inside_s5 || (hit != 4'd0);
		end
	end

	assign blk = inside_s6;
endmodule
`default_nettype wire

@@ design/segment_obstacle_collision_test_unit.sv @@
// Segment/obstacle collision test, top level: request and response channels,
// APB register port and the six-stage pipeline. Depends on soct_pkg,
// soct_req_if, soct_rsp_if, soct_circle and soct_rect.
//
// Usage: each request on req carries one path segment and one obstacle; one
// response on rsp carries blocked for it, in request order. A request is taken
// when req.valid and req.ready are both high, a response when rsp.valid and
// rsp.ready are.
// A new request is taken in every cycle while the receiver does not stall: the
// work is split into six register stages (input, differences, products, sums,
// wide squares, final compare).
// When the receiver stalls, the last stage holds its response and each earlier
// stage still advances into an empty slot ahead, so up to six requests are held
// before req.ready drops.
// The vehicle_width register (byte address 0) is written over APB in the access
// phase, with psel, penable and pwrite high; it is read back at the same address.
// Write it only while no request is in flight.
// Reset empties the pipeline and sets vehicle_width to 300.
`default_nettype none
module segment_obstacle_collision_test_unit import soct_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	soct_req_if.sink req,
	soct_rsp_if.source rsp,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [9:0] vehicle_width_q;
	logic [6:1] v;
	logic [7:1] adv;
	stage_en_t en;
	logic [6:1] circ, rect;
	logic signed [CW-1:0] sx_s1, sy_s1, ex_s1, ey_s1, cx_s1, cy_s1;
	logic [9:0] a_s1, b_s1;
	logic sq_s1;
	logic blk_c, blk_r;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_VEHICLE_WIDTH) ? {22'd0, vehicle_width_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vehicle_width_q <= VEHICLE_WIDTH_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_VEHICLE_WIDTH) begin
			vehicle_width_q <= pwdata[9:0];
		end
	end

	// A stage moves on when it is empty or the stage after it moves on.
	always_comb begin
		adv[7] = rsp.ready;
		for (int k = 6; k >= 1; k--)
			adv[k] = !v[k] || adv[k + 1];
	end

	assign en = '{s2: adv[2], s3: adv[3], s4: adv[4], s5: adv[5], s6: adv[6]};
	assign req.ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (adv[1])
				v[1] <= req.valid;
			for (int k = 2; k <= 6; k++)
				if (adv[k])
					v[k] <= v[k - 1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			sx_s1 <= req.start_x;
			sy_s1 <= req.start_y;
			ex_s1 <= req.end_x;
			ey_s1 <= req.end_y;
			cx_s1 <= req.centre_x;
			cy_s1 <= req.centre_y;
			a_s1 <= req.size_a;
			b_s1 <= req.size_b;
			sq_s1 <= req.obstacle_kind == KIND_SQUARE;
			circ[1] <= req.obstacle_present && req.obstacle_kind == KIND_CIRCLE;
			rect[1] <= req.obstacle_present
				&& (req.obstacle_kind == KIND_RECT || req.obstacle_kind == KIND_SQUARE);
		end
		for (int k = 2; k <= 6; k++)
			if (adv[k]) begin
				circ[k] <= circ[k - 1];
				rect[k] <= rect[k - 1];
			end
	end

	soct_circle u_circle (
		.clk(clk), .en(en),
		.sx(sx_s1), .sy(sy_s1), .ex(ex_s1), .ey(ey_s1), .cx(cx_s1), .cy(cy_s1),
		.a(a_s1), .rw(vehicle_width_q), .blk(blk_c)
	);

	soct_rect u_rect (
		.clk(clk), .en(en),
		.sx(sx_s1), .sy(sy_s1), .ex(ex_s1), .ey(ey_s1), .cx(cx_s1), .cy(cy_s1),
		.a(a_s1), .b(b_s1), .square(sq_s1), .rw(vehicle_width_q), .blk(blk_r)
	);

	assign rsp.valid = v[6];
	assign rsp.blocked = (circ[6] && blk_c) || (rect[6] && blk_r);

`ifndef ASSERT_OFF
	a_kind_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		v[6] |-> $onehot0({circ[6], rect[6]}))
		else $error("circle and rectangle both selected");

	a_absent_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(v[6] && !circ[6] && !rect[6]) |-> !rsp.blocked)
		else $error("blocked set for an absent or unsupported obstacle");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v[1] |-> req.ready)
		else $error("request refused with an empty input stage");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v[5] && adv[6]) |=> v[6])
		else $error("a request was lost between the last two stages");
`endif
endmodule
`default_nettype wire

@@ bench/tb_segment_obstacle_collision_test_unit.sv @@
// Testbench for the segment/obstacle collision test unit: directed table, then
// random segment/obstacle requests checked against a predictor of blocked.
// Depends on soct_pkg, soct_req_if, soct_rsp_if and the unit's RTL.
module tb_segment_obstacle_collision_test_unit;
	import soct_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	soct_req_if req ();
	soct_rsp_if rsp ();

	segment_obstacle_collision_test_unit dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	typedef struct {
		logic signed [CW-1:0] sx, sy, ex, ey, cx, cy;
		logic present;
		logic [1:0] kind;
		logic [9:0] a, b;
	} request_t;

	logic [9:0] width_mm = VEHICLE_WIDTH_RESET;
	bit blocked_q[$];
	int errors = 0;
	int cycles = 0;
	int n_req = 0, n_blocked = 0;
	bit no_idle = 0;

	// Predictor: exact integer geometry, circle on squares, boxes on doubled coords.
	function automatic longint side(longint px, longint py, longint qx, longint qy,
			longint rx, longint ry);
		longint v;
		v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
		return (v == 0) ? 0 : ((v > 0) ? 1 : 2);
	endfunction

	function automatic bit cuts(longint ax, longint ay, longint bx, longint by,
			longint cx, longint cy, longint dx, longint dy);
		return side(ax, ay, bx, by, cx, cy) != side(ax, ay, bx, by, dx, dy) &&
			side(cx, cy, dx, dy, ax, ay) != side(cx, cy, dx, dy, bx, by);
	endfunction

	function automatic bit predict_blocked(request_t r, logic [9:0] w);
		longint dx, dy, fx, fy, l2, dt, rr, gx, gy, lf, rt, bt, tp;
		longint ax, ay, bx, by, hb, wl;
		logic [127:0] lhs, rhs;
		if (!r.present) return 0;
		wl = longint'(w);
		if (r.kind == KIND_CIRCLE) begin
			rr = longint'(r.a) + (wl >>> 1);
			dx = r.ex - r.sx; dy = r.ey - r.sy;
			fx = r.cx - r.sx; fy = r.cy - r.sy;
			l2 = dx * dx + dy * dy;
			dt = fx * dx + fy * dy;
			if (l2 == 0 || dt <= 0) return fx * fx + fy * fy <= rr * rr;
			if (dt >= l2) begin
				gx = r.cx - r.ex; gy = r.cy - r.ey;
				return gx * gx + gy * gy <= rr * rr;
			end
			gx = dx * fy - dy * fx;
			if (gx < 0) gx = -gx;
			lhs = 128'(gx) * 128'(gx);
			rhs = 128'(rr * rr) * 128'(l2);
			return lhs <= rhs;
		end
		if (r.kind != KIND_RECT && r.kind != KIND_SQUARE) return 0;
		hb = (r.kind == KIND_RECT) ? longint'(r.b) : longint'(r.a);
		ax = 2 * r.sx; ay = 2 * r.sy; bx = 2 * r.ex; by = 2 * r.ey;
		lf = 2 * r.cx - (2 * longint'(r.a) + wl); rt = 2 * r.cx + (2 * longint'(r.a) + wl);
		bt = 2 * r.cy - (2 * hb + wl); tp = 2 * r.cy + (2 * hb + wl);
		if ((ax >= lf && ax <= rt && ay >= bt && ay <= tp) ||
				(bx >= lf && bx <= rt && by >= bt && by <= tp)) return 1;
		return cuts(ax, ay, bx, by, lf, bt, rt, bt) || cuts(ax, ay, bx, by, rt, bt, rt, tp) ||
			cuts(ax, ay, bx, by, rt, tp, lf, tp) || cuts(ax, ay, bx, by, lf, tp, lf, bt);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("segment_obstacle_collision_test_unit test failed");
			$finish;
		end
	end

	// Response checker with random backpressure bursts.
	int stall_left = 0;
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (blocked_q.size() == 0) begin
				$error("blocked: no request outstanding, actual %0b", rsp.blocked);
				errors++;
			end else begin
				bit want;
				want = blocked_q.pop_front();
				if (want !== rsp.blocked) begin
					$error("blocked: expected %0b actual %0b", want, rsp.blocked);
					errors++;
				end
				if (want) n_blocked++;
			end
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp.ready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 7);
			rsp.ready <= 1'b0;
		end else
			rsp.ready <= 1'b1;
	end

	initial begin
		req.valid = 1'b0;
		{req.start_x, req.start_y, req.end_x, req.end_y} = '0;
		{req.centre_x, req.centre_y, req.size_a, req.size_b} = '0;
		req.obstacle_present = 1'b0;
		req.obstacle_kind = KIND_CIRCLE;
		rsp.ready = 1'b0;
	end

	task automatic write_width(logic [9:0] w);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_W'(REG_VEHICLE_WIDTH); pwdata <= 32'(w);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		width_mm = w;
		@(posedge clk);
		if (prdata[9:0] !== w) begin
			$error("vehicle_width: expected %0d actual %0d", w, prdata[9:0]);
			errors++;
		end
	endtask

	// Drives one request; an optional idle burst first. A typed-in expectation
	// (0 or 1) is checked against the predictor so the table stays honest.
	task automatic send(request_t r, int typed);
		bit p;
		p = predict_blocked(r, width_mm);
		if (typed >= 0 && p != typed[0]) begin
			$error("blocked: expected %0d actual %0b (table)", typed, p);
			errors++;
		end
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.start_x <= r.sx; req.start_y <= r.sy; req.end_x <= r.ex; req.end_y <= r.ey;
		req.obstacle_present <= r.present; req.obstacle_kind <= r.kind;
		req.centre_x <= r.cx; req.centre_y <= r.cy; req.size_a <= r.a; req.size_b <= r.b;
		do @(posedge clk); while (!req.ready);
		blocked_q.push_back(p);
		n_req++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (blocked_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic request_t mk(int sx, int sy, int ex, int ey, bit pr, logic [1:0] k,
			int cx, int cy, int a, int b);
		request_t r;
		r.sx = CW'(sx); r.sy = CW'(sy); r.ex = CW'(ex); r.ey = CW'(ey);
		r.present = pr; r.kind = k;
		r.cx = CW'(cx); r.cy = CW'(cy); r.a = 10'(a); r.b = 10'(b);
		return r;
	endfunction

	function automatic logic signed [CW-1:0] rc();
		return $urandom_range(0, 3) == 0 ? CW'($urandom) : CW'($signed($urandom_range(0, 1600)) - 800);
	endfunction

	function automatic request_t rnd();
		request_t r;
		r.sx = rc(); r.sy = rc(); r.cx = rc(); r.cy = rc();
		if ($urandom_range(0, 9) == 0) begin
			r.ex = r.sx; r.ey = r.sy;
		end else if ($urandom_range(0, 4) == 0) begin
			r.ex = r.sx; r.ey = rc();
		end else begin
			r.ex = rc(); r.ey = rc();
		end
		r.present = $urandom_range(0, 9) != 0;
		r.kind = 2'($urandom_range(0, 3));
		r.a = $urandom_range(0, 3) == 0 ? 10'($urandom) : 10'($urandom_range(0, 300));
		r.b = $urandom_range(0, 3) == 0 ? 10'($urandom) : 10'($urandom_range(0, 300));
		return r;
	endfunction

	request_t dir[$];
	int exp_tab[$];

	initial begin
		logic [9:0] widths[4];
		widths = '{10'd0, 10'd1023, 10'd51, 10'd300};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table at reset width (300, so circles grow by 150, boxes by 300 doubled).
		dir = '{
			mk(0, 0, 100, 0, 1'b0, KIND_CIRCLE, 0, 0, 100, 0),
			mk(0, 0, 100, 0, 1'b1, 2'd3, 0, 0, 100, 100),
			mk(0, 0, 100, 0, 1'b1, KIND_CIRCLE, 0, 0, 0, 0),
			mk(-4096, -4096, 4095, 4095, 1'b1, KIND_CIRCLE, 4095, -4096, 1023, 1023),
			mk(-4096, 4095, 4095, 4095, 1'b1, KIND_RECT, 0, 0, 1023, 1023),
			mk(0, 0, 0, 0, 1'b1, KIND_CIRCLE, 250, 0, 100, 0),
			mk(0, 0, 0, 0, 1'b1, KIND_CIRCLE, 251, 0, 100, 0),
			mk(500, 500, 500, 500, 1'b1, KIND_SQUARE, 0, 0, 100, 7),
			mk(0, 0, 0, 0, 1'b1, KIND_SQUARE, 0, 0, 0, 1023),
			mk(-1000, 400, 1000, 400, 1'b1, KIND_RECT, 0, 0, 500, 250),
			mk(-1000, 0, 1000, 0, 1'b1, KIND_RECT, 0, 0, 10, 10),
			mk(-1000, -1000, 1000, 1000, 1'b1, KIND_SQUARE, 0, 0, 10, 0),
			mk(-1000, 0, 1000, 0, 1'b1, KIND_CIRCLE, 0, 300, 150, 0),
			mk(-1000, 0, 1000, 0, 1'b1, KIND_CIRCLE, 0, 301, 150, 0),
			mk(-4096, -4096, -4096, -4096, 1'b1, KIND_RECT, 4095, 4095, 0, 0),
			mk(-4096, 160, 4095, 160, 1'b1, KIND_RECT, 0, 0, 0, 10),
			mk(-200, 0, -161, 0, 1'b1, KIND_SQUARE, 0, 0, 10, 0)
		};
		exp_tab = '{0, 0, 1, 0, 0, 1, 0, 0, 1, -1, 1, 1, 1, 0, 0, -1, -1};
		foreach (dir[i]) send(dir[i], exp_tab[i]);
		drain();

		// Random phases, each with its own robot width including the extremes.
		foreach (widths[w]) begin
			write_width(widths[w]);
			for (int i = 0; i < 100; i++) send(rnd(), -1);
			drain();
		end
		write_width(10'($urandom));
		no_idle = 1;
		for (int i = 0; i < 60; i++) send(rnd(), -1);
		req.valid <= 1'b0;
		while (blocked_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);

		$display("Covered %0d requests over six robot widths, %0d of them blocked.",
			n_req, n_blocked);
		if (errors == 0)
			$display("segment_obstacle_collision_test_unit test passed");
		else
			$display("segment_obstacle_collision_test_unit test failed");
		$finish;
	end
endmodule

@@ filelist.f @@
design/soct_pkg.sv
design/soct_req_if.sv
design/soct_rsp_if.sv
design/soct_circle.sv
design/soct_rect.sv
design/segment_obstacle_collision_test_unit.sv
bench/tb_segment_obstacle_collision_test_unit.sv
